[hw/rtl/prrt_pkg.sv]
package prrt_pkg;

    localparam int MaxRegions = 64;
    localparam int IdxW       = $clog2(MaxRegions);
    localparam int CntW       = $clog2(MaxRegions + 1);
    localparam int AddrW      = 48;
    localparam int WordW      = 64;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_LOAD     = 2'd1,
        OP_RELOCATE = 2'd2,
        OP_SPARE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_PASSED    = 3'd0,
        ST_RELOCATED = 3'd1,
        ST_NO_REGION = 3'd2,
        ST_STORED    = 3'd3,
        ST_FULL      = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

    localparam logic [3:0] RegSourceBase  = 4'h0;
    localparam logic [3:0] RegSourceLimit = 4'h8;

    typedef struct packed {
        logic [1:0]       op;
        logic [AddrW-1:0] region_first;
        logic [AddrW-1:0] region_past;
        logic [AddrW-1:0] target_first;
        logic [WordW-1:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic [WordW-1:0] out_word;
        logic [2:0]       status;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // take the input item
        logic clear;      // empty the table
        logic load;       // store captured entry
        logic scan_start; // reset scan index
        logic scan_step;  // check one entry
        logic finish;     // form result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic in_range;
        logic hit;
        logic scan_last;
    } t_stat;

endpackage

[hw/rtl/prrt_ctrl.sv]
module prrt_ctrl import prrt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture    = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_FINISH;
                end
            end
            S_FINISH: begin
                // decide action on the captured item
                if (i_stat.op == OP_RELOCATE && i_stat.in_range) begin
                    o_cmd.scan_step = 1'b1;
                    n_state = (i_stat.hit || i_stat.scan_last) ? S_SCAN : S_FINISH;
                    if (i_stat.hit || i_stat.scan_last) begin
                        n_state = S_SCAN;
                    end
                end else begin
                    o_cmd.clear  = (i_stat.op == OP_CLEAR);
                    o_cmd.load   = (i_stat.op == OP_LOAD);
                    o_cmd.finish = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_SCAN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> !o_out_valid)
        else $error("result shown right after accept");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("ready and valid together");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_step |-> (r_state == S_FINISH))
        else $error("scan outside scan phase");

endmodule

[hw/rtl/prrt_dp.sv]
module prrt_dp import prrt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_in_item            i_item,
    input  t_cmd                i_cmd,
    input  logic [AddrW-1:0]    i_source_base,
    input  logic [AddrW-1:0]    i_source_limit,
    output t_stat               o_stat,
    output t_out_item           o_item
);

    logic [AddrW-1:0] mem_start  [MaxRegions];
    logic [AddrW-1:0] mem_end    [MaxRegions];
    logic [AddrW-1:0] mem_target [MaxRegions];

    t_in_item         r_item;
    logic [CntW-1:0]  r_count;
    logic [IdxW-1:0]  r_idx;
    logic             r_rd_ok;
    logic [AddrW-1:0] r_rd_start, r_rd_end, r_rd_target;
    logic             r_hit;
    logic [AddrW-1:0] r_hit_start, r_hit_target;
    t_out_item        r_out;

    logic             full;
    logic             in_range;
    logic             rd_match;
    logic [IdxW-1:0]  rd_addr;
    logic [WordW-1:0] reloc;

    assign full     = (r_count == CntW'(MaxRegions));
    assign in_range = (r_item.data_word >= {16'd0, i_source_base}) &&
                      (r_item.data_word <  {16'd0, i_source_limit});
    // registered read of entry r_idx, checked the following cycle
    assign rd_match = r_rd_ok && (r_item.data_word >= {16'd0, r_rd_start}) &&
                      (r_item.data_word < {16'd0, r_rd_end});
    assign rd_addr  = i_cmd.scan_step ? r_idx + IdxW'(1) : '0;
    assign reloc    = {16'd0, r_hit_target} + (r_item.data_word - {16'd0, r_hit_start});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            mem_start[r_count[IdxW-1:0]]  <= r_item.region_first;
            mem_end[r_count[IdxW-1:0]]    <= r_item.region_past;
            mem_target[r_count[IdxW-1:0]] <= r_item.target_first;
        end
        r_rd_start  <= mem_start[rd_addr];
        r_rd_end    <= mem_end[rd_addr];
        r_rd_target <= mem_target[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_rd_ok <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.load && !full) begin
                r_count <= r_count + CntW'(1);
            end
            if (i_cmd.scan_start) begin
                r_idx   <= '0;
                r_rd_ok <= (r_count != '0);
                r_hit   <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_idx   <= r_idx + IdxW'(1);
                r_rd_ok <= (CntW'(r_idx) + CntW'(1) < r_count);
                if (rd_match) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.scan_step && rd_match) begin
            r_hit_start  <= r_rd_start;
            r_hit_target <= r_rd_target;
        end
        if (i_cmd.finish) begin
            case (t_op'(r_item.op))
                OP_CLEAR: r_out <= '{out_word: '0, status: ST_CLEARED};
                OP_LOAD:  r_out <= '{out_word: '0, status: full ? ST_FULL : ST_STORED};
                OP_RELOCATE: begin
                    if (!in_range) begin
                        r_out <= '{out_word: r_item.data_word, status: ST_PASSED};
                    end else if (r_hit) begin
                        r_out <= '{out_word: reloc, status: ST_RELOCATED};
                    end else begin
                        r_out <= '{out_word: r_item.data_word, status: ST_NO_REGION};
                    end
                end
                default: r_out <= '{out_word: r_item.data_word, status: ST_PASSED};
            endcase
        end
    end

    assign o_stat.op        = t_op'(r_item.op);
    assign o_stat.in_range  = in_range;
    assign o_stat.hit       = rd_match;
    assign o_stat.scan_last = !r_rd_ok;
    assign o_item           = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxRegions))
        else $error("entry count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_count == '0))
        else $error("clear did not empty table");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && !full) |=> (r_count == $past(r_count) + CntW'(1)))
        else $error("load count mismatch");

endmodule

[hw/rtl/pointer_relocation_range_table.sv]
// Channel | Direction | Handshake                | Payload
// in      | input     | i_in_valid / o_in_ready  | i_in_item  (t_in_item)
// out     | output    | o_out_valid / i_out_ready| o_out_item (t_out_item)
// cfg     | APB write | psel/penable/pwrite      | paddr, pwdata (64-bit)
// Clear, load, spare and out-of-range words pass from accept through the finish state to the result state.
// Relocate in range scans the table one entry per cycle through the memory read
// port, stopping at the first hit or after the last stored entry.
// One transaction in flight; input is accepted again once the result is taken.
// Synchronous active-low reset empties the table and zeroes both registers.
module pointer_relocation_range_table import prrt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [AddrW-1:0] r_source_base, r_source_limit;
    t_cmd             cmd;
    t_stat            stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_base  <= '0;
            r_source_limit <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr == RegSourceBase) begin
                r_source_base <= pwdata[AddrW-1:0];
            end else if (paddr == RegSourceLimit) begin
                r_source_limit <= pwdata[AddrW-1:0];
            end
        end
    end

    always_comb begin
        case (paddr)
            RegSourceBase:  prdata = {16'd0, r_source_base};
            RegSourceLimit: prdata = {16'd0, r_source_limit};
            default:        prdata = '0;
        endcase
    end

    prrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    prrt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_in_item),
        .i_cmd          (cmd),
        .i_source_base  (r_source_base),
        .i_source_limit (r_source_limit),
        .o_stat         (stat),
        .o_item         (o_out_item)
    );

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import prrt_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    pointer_relocation_range_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [AddrW-1:0] win_base, win_limit;
    logic [AddrW-1:0] tbl_first [MaxRegions];
    logic [AddrW-1:0] tbl_past  [MaxRegions];
    logic [AddrW-1:0] tbl_target[MaxRegions];
    logic             tbl_used  [MaxRegions];
    int               tbl_count;

    t_out_item pending_words[$];
    int        errors;
    int        out_hold = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int rand_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
        return $urandom_range(0, 2);
    endfunction

    function automatic t_out_item predict_relocation(t_in_item it);
        t_out_item r;
        r.out_word = '0;
        case (t_op'(it.op))
            OP_CLEAR: begin
                for (int k = 0; k < MaxRegions; k++) tbl_used[k] = 1'b0;
                tbl_count = 0;
                r.status = ST_CLEARED;
            end
            OP_LOAD: begin
                if (tbl_count >= MaxRegions) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_first[tbl_count]  = it.region_first;
                    tbl_past[tbl_count]   = it.region_past;
                    tbl_target[tbl_count] = it.target_first;
                    tbl_used[tbl_count]   = 1'b1;
                    tbl_count++;
                    r.status = ST_STORED;
                end
            end
            OP_RELOCATE: begin
                r.out_word = it.data_word;
                if (it.data_word >= {16'b0, win_base} && it.data_word < {16'b0, win_limit})
                begin
                    r.status = ST_NO_REGION;
                    for (int k = 0; k < MaxRegions; k++) begin
                        if (tbl_used[k] && it.data_word >= {16'b0, tbl_first[k]} &&
                            it.data_word < {16'b0, tbl_past[k]}) begin
                            r.out_word = {16'b0, tbl_target[k]} +
                                         (it.data_word - {16'b0, tbl_first[k]});
                            r.status = ST_RELOCATED;
                            break;
                        end
                    end
                end else begin
                    r.status = ST_PASSED;
                end
            end
            default: begin
                r.out_word = it.data_word;
                r.status = ST_PASSED;
            end
        endcase
        return r;
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        gap = rand_gap();
        @(posedge i_clk);
        repeat (gap) @(posedge i_clk);
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        pending_words.push_back(predict_relocation(it));
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (MaxRegions + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [3:0] addr, logic [AddrW-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= {16'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == RegSourceBase) win_base = value;
        else win_limit = value;
    endtask

    function automatic t_in_item make_item(t_op op, logic [AddrW-1:0] a, logic [AddrW-1:0] b,
                                           logic [AddrW-1:0] c, logic [WordW-1:0] w);
        t_in_item it;
        it.op = op; it.region_first = a; it.region_past = b;
        it.target_first = c; it.data_word = w;
        return it;
    endfunction

    function automatic logic [WordW-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [AddrW-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[AddrW-1:0];
    endfunction

    // scoreboard on the result channel
    always @(posedge i_clk) begin
        t_out_item exp_word;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected result out_word=%h status=%0d",
                       o_out_item.out_word, o_out_item.status);
                errors++;
            end else begin
                exp_word = pending_words.pop_front();
                if (o_out_item.out_word !== exp_word.out_word) begin
                    $error("out_word expected %h actual %h", exp_word.out_word,
                           o_out_item.out_word);
                    errors++;
                end
                if (o_out_item.status !== exp_word.status) begin
                    $error("status expected %0d actual %0d", exp_word.status,
                           o_out_item.status);
                    errors++;
                end
            end
        end
    end

    // result-side stalls: mostly short, now and then long
    always @(posedge i_clk) begin
        if (out_hold > 0) begin
            out_hold    <= out_hold - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            out_hold    <= rand_gap();
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic test_directed();
        logic [AddrW-1:0] top;
        top = '1;
        write_reg(RegSourceBase, 48'h1000);
        write_reg(RegSourceLimit, 48'h9000);
        send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
        send_item(make_item(OP_RELOCATE, 0, 0, 0, 64'h2000));
        send_item(make_item(OP_LOAD, 48'h2000, 48'h3000, 48'hA0000, 0));
        send_item(make_item(OP_LOAD, 48'h2800, 48'h4000, 48'hB0000, 0));
        send_item(make_item(OP_LOAD, 48'h5000, 48'h5000, 48'hC0000, 0));
        send_item(make_item(OP_LOAD, 48'h7000, 48'h6000, 48'hC0000, 0));
        send_item(make_item(OP_LOAD, 0, top, top, 0));
        send_item(make_item(OP_RELOCATE, 0, 0, 0, 64'h2000));
        send_item(make_item(OP_RELOCATE, 0, 0, 0, 64'h2FFF));
        send_item(make_item(OP_RELOCATE, 0, 0, 0, 64'h2900));
        send_item(make_item(OP_RELOCATE, 0, 0, 0, 64'h3000));
        send_item(make_item(OP_RELOCATE, 0, 0, 0, 64'h5000));
        send_item(make_item(OP_RELOCATE, 0, 0, 0, 64'h0FFF));
        send_item(make_item(OP_RELOCATE, 0, 0, 0, 64'h9000));
        send_item(make_item(OP_RELOCATE, 0, 0, 0, '1));
        send_item(make_item(OP_SPARE, top, top, top, '1));
        send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
        send_item(make_item(OP_RELOCATE, 0, 0, 0, 64'h2000));
        wait_drained();
        // empty window, then full window
        write_reg(RegSourceBase, 48'h9000);
        send_item(make_item(OP_RELOCATE, 0, 0, 0, 64'h2000));
        wait_drained();
        write_reg(RegSourceBase, 0);
        write_reg(RegSourceLimit, top);
        send_item(make_item(OP_LOAD, 0, top, 0, 0));
        send_item(make_item(OP_RELOCATE, 0, 0, 0, {16'b0, top} - 1));
        send_item(make_item(OP_RELOCATE, 0, 0, 0, {16'b0, top}));
        wait_drained();
    endtask

    task automatic test_full_table();
        send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
        for (int k = 0; k < MaxRegions + 3; k++)
            send_item(make_item(OP_LOAD, rand48(), rand48(), rand48(), 0));
        send_item(make_item(OP_RELOCATE, 0, 0, 0, rand64()));
        wait_drained();
    endtask

    // copy sessions: clear, load a set of blocks, stream words mostly inside them
    task automatic test_random_sessions();
        logic [AddrW-1:0] base, span;
        logic [AddrW-1:0] bf[$];
        logic [AddrW-1:0] bp[$];
        int nblk, sent, pick;
        logic [WordW-1:0] w;
        sent = 0;
        while (sent < 1450) begin
            base = rand48() & 48'hFFFF_FFF0_0000;
            span = 48'h10_0000;
            if ($urandom_range(0, 5) == 0) begin
                write_reg(RegSourceBase, rand48());
                write_reg(RegSourceLimit, rand48());
            end else begin
                write_reg(RegSourceBase, base);
                write_reg(RegSourceLimit, base + span);
            end
            send_item(make_item(OP_CLEAR, rand48(), rand48(), rand48(), rand64()));
            bf.delete(); bp.delete();
            nblk = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
            for (int k = 0; k < nblk; k++) begin
                bf.push_back(base + $urandom_range(0, 32'hF0000));
                bp.push_back(bf[k] + $urandom_range(0, 32'h2000) - ($urandom_range(0, 9) == 0 ?
                             48'h10 : 48'h0));
                send_item(make_item(OP_LOAD, bf[k], bp[k], rand48(), rand64()));
                sent++;
            end
            for (int j = 0; j < 60; j++) begin
                pick = $urandom_range(0, nblk - 1);
                case ($urandom_range(0, 9))
                    0: w = rand64();
                    1: w = {16'b0, base} + $urandom_range(0, 32'hFFFFF);
                    2: w = {16'b0, bp[pick]} - $urandom_range(0, 1);
                    default: w = {16'b0, bf[pick]} + $urandom_range(0, 32'h2000);
                endcase
                send_item(make_item(($urandom_range(0, 29) == 0) ? OP_SPARE :
                                    ($urandom_range(0, 39) == 0) ? OP_LOAD : OP_RELOCATE,
                                    rand48(), rand48(), rand48(), w));
                sent++;
                if (sent == 700) begin
                    // hold input until the result queue empties
                    while (pending_words.size() != 0) @(posedge i_clk);
                end
            end
            wait_drained();
        end
    endtask

    initial begin
        errors      = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        win_base = '0; win_limit = '0; tbl_count = 0;
        for (int k = 0; k < MaxRegions; k++) tbl_used[k] = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table();
        test_random_sessions();
        wait_drained();
        if (errors == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/prrt_pkg.sv
hw/rtl/prrt_ctrl.sv
hw/rtl/prrt_dp.sv
hw/rtl/pointer_relocation_range_table.sv
bench/testbench.sv
